// File: rtl/fdsa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdsa_pkg
// Shared types, opcodes and constants of the Forth data stack ALU.
// ----------------------------------------------------------------------------
package fdsa_pkg;

  localparam int unsigned STACK_DEPTH_DEF = 32;

  typedef enum logic [4:0] {
    OP_PUSH = 5'd0, OP_DROP = 5'd1, OP_DUP = 5'd2, OP_QDUP = 5'd3,
    OP_SWAP = 5'd4, OP_OVER = 5'd5,
    OP_LTZ = 5'd6, OP_EQZ = 5'd7, OP_GTZ = 5'd8, OP_INC1 = 5'd9,
    OP_DEC1 = 5'd10, OP_INC2 = 5'd11, OP_DEC2 = 5'd12, OP_ABS = 5'd13,
    OP_NEG = 5'd14,
    OP_ADD = 5'd15, OP_SUB = 5'd16, OP_MUL = 5'd17, OP_DIV = 5'd18,
    OP_AND = 5'd19, OP_OR = 5'd20, OP_XOR = 5'd21, OP_LT = 5'd22,
    OP_EQ = 5'd23, OP_GT = 5'd24, OP_MAX = 5'd25, OP_MIN = 5'd26,
    OP_MOD = 5'd27
  } op_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_UNDER = 2'd1, ST_OVER = 2'd2, ST_DIVZ = 2'd3
  } status_t;

  typedef struct packed {
    logic [4:0]         req_type;
    logic signed [31:0] literal;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] top_value;
    logic signed [31:0] popped_value;
    logic [5:0]         depth;
  } rsp_t;

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_EXEC, S_DIV, S_WB2, S_TOP, S_DONE
  } state_t;

  typedef struct packed {
    logic        start;
    logic        want_rem;
    logic [31:0] a;
    logic [31:0] b;
  } div_cmd_t;

  typedef struct packed {
    logic        done;
    logic [31:0] result;
  } div_rsp_t;

endpackage

// File: rtl/fdsa_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdsa_divider
// Restoring signed divider, one quotient bit per cycle, truncating.
// ----------------------------------------------------------------------------
module fdsa_divider (
  input  logic               clk,
  input  logic               rst,
  input  fdsa_pkg::div_cmd_t cmd,
  output fdsa_pkg::div_rsp_t rsp
);

  logic        busy;
  logic [5:0]  count;
  logic [31:0] quo;
  logic [31:0] rem;
  logic [31:0] divisor;
  logic        neg_q;
  logic        neg_r;
  logic        want_rem;
  logic        done;
  logic [32:0] trial;
  logic [31:0] rem_shift;

  assign rem_shift = {rem[30:0], quo[31]};
  assign trial     = {1'b0, rem_shift} - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy     <= 1'b1;
        count    <= 6'd32;
        quo      <= cmd.a[31] ? 32'd0 - cmd.a : cmd.a;
        divisor  <= cmd.b[31] ? 32'd0 - cmd.b : cmd.b;
        rem      <= '0;
        neg_q    <= cmd.a[31] ^ cmd.b[31];
        neg_r    <= cmd.a[31];
        want_rem <= cmd.want_rem;
      end else if (busy) begin
        if (trial[32]) begin
          rem <= rem_shift;
          quo <= {quo[30:0], 1'b0};
        end else begin
          rem <= trial[31:0];
          quo <= {quo[30:0], 1'b1};
        end
        count <= count - 6'd1;
        if (count == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done   = done;
  assign rsp.result = want_rem ? (neg_r ? 32'd0 - rem : rem)
                               : (neg_q ? 32'd0 - quo : quo);

endmodule

// File: rtl/forth_data_stack_alu_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// forth_data_stack_alu_unit
// Forth data stack held in a synchronous memory with a small integer ALU.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake          Payload
// req      in         req_valid/stall    fdsa_pkg::req_t
// rsp      out        rsp_valid/stall    fdsa_pkg::rsp_t
//
// A request goes from acceptance to response through these steps: read the
// second entry, read the top, execute and write, read the new top; swap adds
// a write state, and divide and mod wait for the bit-serial divider. The
// memory's single read port sets this order. Reset empties the stack; the
// stack memory is not cleared. A stalled response holds the unit, and one new
// request is taken while the previous response still waits.
module forth_data_stack_alu_unit #(
  parameter int unsigned STACK_DEPTH = fdsa_pkg::STACK_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  fdsa_pkg::req_t  req,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output fdsa_pkg::rsp_t  rsp
);

  localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned DW = $clog2(STACK_DEPTH + 1);

  logic [31:0] mem [STACK_DEPTH];
  logic [31:0] rd_data;
  logic [AW-1:0] rd_addr;
  logic        rd_en;
  logic        wr_en;
  logic [AW-1:0] wr_addr;
  logic [31:0] wr_data;

  fdsa_pkg::state_t state, state_next;
  logic [DW-1:0] depth;
  logic [DW-1:0] depth_next;
  logic [4:0]    op;
  logic [31:0]   lit;
  logic [31:0]   a_q;
  logic [31:0]   b_val;
  logic [31:0]   a_val;
  logic [1:0]    st;
  logic [31:0]   popped;
  logic [31:0]   top;
  logic          pend_valid;
  fdsa_pkg::req_t pend;
  logic          accept;
  logic          start;
  logic [31:0]   mul_res;

  fdsa_pkg::div_cmd_t div_cmd;
  fdsa_pkg::div_rsp_t div_rsp;

  fdsa_divider u_div (.clk(clk), .rst(rst), .cmd(div_cmd), .rsp(div_rsp));

  // Memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end

  assign req_stall = pend_valid;
  assign accept    = req_valid && !pend_valid;
  assign start     = (state == fdsa_pkg::S_IDLE) && pend_valid;
  assign rsp_valid = (state == fdsa_pkg::S_DONE);

  // The second entry is latched in S_READ; the top comes straight from the
  // read register, which holds until the next read in S_TOP.
  assign a_val   = a_q;
  assign b_val   = rd_data;
  assign mul_res = a_val * b_val;

  // Execution-stage decode.
  logic        need1, need2, grows, shrinks, is_div, do_push, wr_a, wr_top;
  logic [31:0] alu;
  logic [DW-1:0] d_after;
  logic [1:0]  st_exec;

  always_comb begin
    logic signed [31:0] sa, sb;
    sa = a_val;
    sb = b_val;
    need1 = 1'b0; need2 = 1'b0; grows = 1'b0; shrinks = 1'b0;
    is_div = 1'b0; wr_a = 1'b0; wr_top = 1'b0; alu = b_val;
    unique case (op)
      fdsa_pkg::OP_PUSH: begin grows = 1'b1; alu = lit; end
      fdsa_pkg::OP_DROP: begin need1 = 1'b1; shrinks = 1'b1; end
      fdsa_pkg::OP_DUP:  begin need1 = 1'b1; grows = 1'b1; end
      fdsa_pkg::OP_QDUP: begin need1 = 1'b1; grows = (b_val != 32'd0); end
      fdsa_pkg::OP_SWAP: begin need2 = 1'b1; wr_top = 1'b1; alu = a_val; end
      fdsa_pkg::OP_OVER: begin need2 = 1'b1; grows = 1'b1; alu = a_val; end
      fdsa_pkg::OP_LTZ:  begin need1 = 1'b1; wr_top = 1'b1; alu = {31'd0, b_val[31]}; end
      fdsa_pkg::OP_EQZ:  begin
        need1 = 1'b1; wr_top = 1'b1; alu = {31'd0, b_val == 32'd0};
      end
      fdsa_pkg::OP_GTZ:  begin need1 = 1'b1; wr_top = 1'b1; alu = {31'd0, sb > 0}; end
      fdsa_pkg::OP_INC1: begin need1 = 1'b1; wr_top = 1'b1; alu = b_val + 32'd1; end
      fdsa_pkg::OP_DEC1: begin need1 = 1'b1; wr_top = 1'b1; alu = b_val - 32'd1; end
      fdsa_pkg::OP_INC2: begin need1 = 1'b1; wr_top = 1'b1; alu = b_val + 32'd2; end
      fdsa_pkg::OP_DEC2: begin need1 = 1'b1; wr_top = 1'b1; alu = b_val - 32'd2; end
      fdsa_pkg::OP_ABS:  begin
        need1 = 1'b1; wr_top = 1'b1; alu = b_val[31] ? 32'd0 - b_val : b_val;
      end
      fdsa_pkg::OP_NEG:  begin need1 = 1'b1; wr_top = 1'b1; alu = 32'd0 - b_val; end
      fdsa_pkg::OP_ADD:  begin
        need2 = 1'b1; shrinks = 1'b1; wr_a = 1'b1; alu = a_val + b_val;
      end
      fdsa_pkg::OP_SUB:  begin
        need2 = 1'b1; shrinks = 1'b1; wr_a = 1'b1; alu = a_val - b_val;
      end
      fdsa_pkg::OP_MUL:  begin
        need2 = 1'b1; shrinks = 1'b1; wr_a = 1'b1; alu = mul_res;
      end
      fdsa_pkg::OP_DIV, fdsa_pkg::OP_MOD: begin
        need2 = 1'b1; shrinks = 1'b1; wr_a = 1'b1; is_div = 1'b1;
      end
      fdsa_pkg::OP_AND:  begin
        need2 = 1'b1; shrinks = 1'b1; wr_a = 1'b1; alu = a_val & b_val;
      end
      fdsa_pkg::OP_OR:   begin
        need2 = 1'b1; shrinks = 1'b1; wr_a = 1'b1; alu = a_val | b_val;
      end
      fdsa_pkg::OP_XOR:  begin
        need2 = 1'b1; shrinks = 1'b1; wr_a = 1'b1; alu = a_val ^ b_val;
      end
      fdsa_pkg::OP_LT:   begin
        need2 = 1'b1; shrinks = 1'b1; wr_a = 1'b1; alu = {31'd0, sa < sb};
      end
      fdsa_pkg::OP_EQ:   begin
        need2 = 1'b1; shrinks = 1'b1; wr_a = 1'b1; alu = {31'd0, a_val == b_val};
      end
      fdsa_pkg::OP_GT:   begin
        need2 = 1'b1; shrinks = 1'b1; wr_a = 1'b1; alu = {31'd0, sa > sb};
      end
      fdsa_pkg::OP_MAX:  begin
        need2 = 1'b1; shrinks = 1'b1; wr_a = 1'b1; alu = (sa < sb) ? b_val : a_val;
      end
      fdsa_pkg::OP_MIN:  begin
        need2 = 1'b1; shrinks = 1'b1; wr_a = 1'b1; alu = (sb < sa) ? b_val : a_val;
      end
      default: ;
    endcase
    st_exec = fdsa_pkg::ST_OK;
    if ((need1 && depth == '0) || (need2 && depth < DW'(2)))
      st_exec = fdsa_pkg::ST_UNDER;
    else if (grows && depth == DW'(STACK_DEPTH))
      st_exec = fdsa_pkg::ST_OVER;
    else if (is_div && b_val == 32'd0)
      st_exec = fdsa_pkg::ST_DIVZ;
    do_push = grows && (st_exec == fdsa_pkg::ST_OK);
    d_after = depth;
    if (st_exec == fdsa_pkg::ST_OK) begin
      if (grows) d_after = depth + DW'(1);
      else if (shrinks) d_after = depth - DW'(1);
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      fdsa_pkg::S_IDLE: if (pend_valid) state_next = fdsa_pkg::S_READ;
      fdsa_pkg::S_READ: state_next = fdsa_pkg::S_EXEC;
      fdsa_pkg::S_EXEC: begin
        if (is_div && st_exec == fdsa_pkg::ST_OK) state_next = fdsa_pkg::S_DIV;
        else if (op == fdsa_pkg::OP_SWAP && st_exec == fdsa_pkg::ST_OK)
          state_next = fdsa_pkg::S_WB2;
        else state_next = fdsa_pkg::S_TOP;
      end
      fdsa_pkg::S_DIV:  if (div_rsp.done) state_next = fdsa_pkg::S_TOP;
      fdsa_pkg::S_WB2:  state_next = fdsa_pkg::S_TOP;
      fdsa_pkg::S_TOP:  state_next = fdsa_pkg::S_DONE;
      fdsa_pkg::S_DONE: if (!rsp_stall) state_next = fdsa_pkg::S_IDLE;
      default: state_next = fdsa_pkg::S_IDLE;
    endcase
  end

  // Memory port control.
  always_comb begin
    rd_en = 1'b0; rd_addr = '0; wr_en = 1'b0; wr_addr = '0; wr_data = alu;
    div_cmd.start = 1'b0;
    div_cmd.want_rem = (op == fdsa_pkg::OP_MOD);
    div_cmd.a = a_val;
    div_cmd.b = b_val;
    unique case (state)
      fdsa_pkg::S_IDLE: begin
        // Read the second entry.
        rd_en = 1'b1; rd_addr = AW'(depth - DW'(2));
      end
      fdsa_pkg::S_READ: begin
        rd_en = 1'b1; rd_addr = AW'(depth - DW'(1));
      end
      fdsa_pkg::S_EXEC: begin
        if (st_exec == fdsa_pkg::ST_OK) begin
          if (do_push) begin
            wr_en = 1'b1; wr_addr = AW'(depth);
          end else if (wr_a && !is_div) begin
            wr_en = 1'b1; wr_addr = AW'(depth - DW'(2));
          end else if (wr_top) begin
            wr_en = 1'b1; wr_addr = AW'(depth - DW'(1));
          end
        end
        div_cmd.start = is_div && (st_exec == fdsa_pkg::ST_OK);
      end
      fdsa_pkg::S_DIV: begin
        wr_en = div_rsp.done; wr_addr = AW'(depth - DW'(1)); wr_data = div_rsp.result;
      end
      fdsa_pkg::S_WB2: begin
        wr_en = 1'b1; wr_addr = AW'(depth - DW'(2)); wr_data = b_val;
      end
      fdsa_pkg::S_TOP: begin
        rd_en = 1'b1; rd_addr = AW'(depth - DW'(1));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= fdsa_pkg::S_IDLE;
      depth      <= '0;
      pend_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) pend_valid <= 1'b1;
      else if (start) pend_valid <= 1'b0;
      if (state == fdsa_pkg::S_EXEC) depth <= d_after;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) pend <= req;
    if (start) begin
      op  <= pend.req_type;
      lit <= pend.literal;
    end
    if (state == fdsa_pkg::S_READ) a_q <= rd_data;
    if (state == fdsa_pkg::S_EXEC) begin
      st     <= st_exec;
      popped <= (op == fdsa_pkg::OP_DROP && st_exec == fdsa_pkg::ST_OK) ?
                rd_data : 32'd0;
    end
  end

  always_comb begin
    top = (depth == '0) ? 32'd0 : rd_data;
  end

  logic [31:0] top_hold;
  logic        top_cap;
  assign top_cap = (state == fdsa_pkg::S_TOP);
  logic top_ld;
  always_ff @(posedge clk) begin
    if (rst) top_ld <= 1'b0;
    else     top_ld <= top_cap;
    if (top_ld) top_hold <= top;
  end

  assign rsp.status       = st;
  assign rsp.top_value    = top_ld ? top : top_hold;
  assign rsp.popped_value = popped;
  assign rsp.depth        = 6'(depth);

endmodule

// File: tb/forth_data_stack_alu_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// forth_data_stack_alu_unit_tb
// Self-checking bench for the Forth data stack ALU. Requests are queued by a
// stimulus process, driven with random gaps, and each response is checked
// field by field against a behavioral model of the stack kept in the bench.
// ----------------------------------------------------------------------------
module forth_data_stack_alu_unit_tb;

  localparam int unsigned DEPTH = fdsa_pkg::STACK_DEPTH_DEF;
  localparam logic [4:0] OP_RSV_LO = 5'd28;
  localparam logic [4:0] OP_RSV_HI = 5'd31;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  fdsa_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  fdsa_pkg::rsp_t rsp;

  fdsa_pkg::req_t pending_reqs[$];
  fdsa_pkg::rsp_t expected_rsps[$];
  logic [31:0] model_stack[DEPTH];
  int unsigned model_depth = 0;
  int unsigned mismatches = 0;
  bit req_taken = 1'b0;
  int gap_left = 0;
  int stall_left = 0;

  forth_data_stack_alu_unit i_dut (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
  );

  always #10 clk = ~clk;

  function automatic int rand_gap();
    if ($urandom_range(0, 99) < 50) return 0;
    if ($urandom_range(0, 99) < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic lt_signed(logic [31:0] a, logic [31:0] b);
    return $signed(a) < $signed(b);
  endfunction

  function automatic logic [31:0] trunc_div(logic [31:0] a, logic [31:0] b, bit want_rem);
    logic [31:0] ma, mb, q, r;
    ma = a[31] ? -a : a;
    mb = b[31] ? -b : b;
    q = ma / mb;
    r = ma % mb;
    if (want_rem) return a[31] ? -r : r;
    return (a[31] ^ b[31]) ? -q : q;
  endfunction

  // Runs one primitive on the bench's copy of the stack.
  function automatic fdsa_pkg::rsp_t stack_exec(fdsa_pkg::req_t r);
    fdsa_pkg::rsp_t o;
    logic [31:0] a, b, x, t;
    logic [4:0] op;
    o = '0;
    op = r.req_type;
    o.status = fdsa_pkg::ST_OK;
    if (op == fdsa_pkg::OP_PUSH) begin
      if (model_depth >= DEPTH) o.status = fdsa_pkg::ST_OVER;
      else begin
        model_stack[model_depth] = r.literal;
        model_depth++;
      end
    end else if (op == fdsa_pkg::OP_DROP) begin
      if (model_depth < 1) o.status = fdsa_pkg::ST_UNDER;
      else begin
        model_depth--;
        o.popped_value = model_stack[model_depth];
      end
    end else if (op == fdsa_pkg::OP_DUP || op == fdsa_pkg::OP_QDUP) begin
      if (model_depth < 1) o.status = fdsa_pkg::ST_UNDER;
      else begin
        x = model_stack[model_depth-1];
        if (op == fdsa_pkg::OP_DUP || x != 0) begin
          if (model_depth >= DEPTH) o.status = fdsa_pkg::ST_OVER;
          else begin
            model_stack[model_depth] = x;
            model_depth++;
          end
        end
      end
    end else if (op == fdsa_pkg::OP_SWAP || op == fdsa_pkg::OP_OVER) begin
      if (model_depth < 2) o.status = fdsa_pkg::ST_UNDER;
      else if (op == fdsa_pkg::OP_SWAP) begin
        t = model_stack[model_depth-1];
        model_stack[model_depth-1] = model_stack[model_depth-2];
        model_stack[model_depth-2] = t;
      end else if (model_depth >= DEPTH) o.status = fdsa_pkg::ST_OVER;
      else begin
        model_stack[model_depth] = model_stack[model_depth-2];
        model_depth++;
      end
    end else if (op <= fdsa_pkg::OP_NEG) begin
      if (model_depth < 1) o.status = fdsa_pkg::ST_UNDER;
      else begin
        x = model_stack[model_depth-1];
        case (op)
          fdsa_pkg::OP_LTZ:  x = {31'd0, x[31]};
          fdsa_pkg::OP_EQZ:  x = {31'd0, x == 0};
          fdsa_pkg::OP_GTZ:  x = {31'd0, lt_signed(0, x)};
          fdsa_pkg::OP_INC1: x = x + 1;
          fdsa_pkg::OP_DEC1: x = x - 1;
          fdsa_pkg::OP_INC2: x = x + 2;
          fdsa_pkg::OP_DEC2: x = x - 2;
          fdsa_pkg::OP_ABS:  x = x[31] ? -x : x;
          default: x = -x;
        endcase
        model_stack[model_depth-1] = x;
      end
    end else if (op <= fdsa_pkg::OP_MOD) begin
      if (model_depth < 2) o.status = fdsa_pkg::ST_UNDER;
      else begin
        b = model_stack[model_depth-1];
        a = model_stack[model_depth-2];
        if ((op == fdsa_pkg::OP_DIV || op == fdsa_pkg::OP_MOD) && b == 0)
          o.status = fdsa_pkg::ST_DIVZ;
        else begin
          case (op)
            fdsa_pkg::OP_ADD: x = a + b;
            fdsa_pkg::OP_SUB: x = a - b;
            fdsa_pkg::OP_MUL: x = a * b;
            fdsa_pkg::OP_DIV: x = trunc_div(a, b, 1'b0);
            fdsa_pkg::OP_AND: x = a & b;
            fdsa_pkg::OP_OR:  x = a | b;
            fdsa_pkg::OP_XOR: x = a ^ b;
            fdsa_pkg::OP_LT:  x = {31'd0, lt_signed(a, b)};
            fdsa_pkg::OP_EQ:  x = {31'd0, a == b};
            fdsa_pkg::OP_GT:  x = {31'd0, lt_signed(b, a)};
            fdsa_pkg::OP_MAX: x = lt_signed(a, b) ? b : a;
            fdsa_pkg::OP_MIN: x = lt_signed(b, a) ? b : a;
            default: x = trunc_div(a, b, 1'b1);
          endcase
          model_stack[model_depth-2] = x;
          model_depth--;
        end
      end
    end
    o.top_value = (model_depth > 0) ? model_stack[model_depth-1] : 32'd0;
    o.depth = model_depth[5:0];
    return o;
  endfunction

  task automatic add_req(logic [4:0] op, logic [31:0] lit);
    fdsa_pkg::req_t r;
    r.req_type = op;
    r.literal = lit;
    pending_reqs.push_back(r);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 32'd0;
      4: return $urandom_range(0, 5);
      5: return -$urandom_range(1, 5);
      default: return $urandom;
    endcase
  endfunction

  // Driver: request payload holds while stalled; valid only drops after acceptance.
  always @(negedge clk) begin
    if (!rst) begin
      if (req_taken) begin
        req_valid <= 1'b0;
        gap_left = rand_gap();
      end else if (!req_valid) begin
        if (gap_left > 0) gap_left--;
        else if (pending_reqs.size() > 0) begin
          req <= pending_reqs.pop_front();
          req_valid <= 1'b1;
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= 1'b0;
        stall_left = rand_gap();
      end
    end
  end

  // Monitor: predict on request acceptance, check on response acceptance.
  always @(posedge clk) begin
    req_taken <= !rst && req_valid && !req_stall;
    if (!rst) begin
      if (req_valid && !req_stall) expected_rsps.push_back(stack_exec(req));
      if (rsp_valid && !rsp_stall) begin
        if (expected_rsps.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected response %p", rsp);
        end else begin
          fdsa_pkg::rsp_t e;
          e = expected_rsps.pop_front();
          if (e.status !== rsp.status || e.top_value !== rsp.top_value ||
              e.popped_value !== rsp.popped_value || e.depth !== rsp.depth) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"mismatch: expected st=%0d top=%h pop=%h d=%0d, ",
                        "got st=%0d top=%h pop=%h d=%0d"},
                       e.status, e.top_value, e.popped_value, e.depth,
                       rsp.status, rsp.top_value, rsp.popped_value, rsp.depth);
          end
        end
      end
    end
  end

  initial begin
    int n;
    int fill;
    logic [4:0] op;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: underflow on empty, extremes, divide corner cases, reserved opcodes, overflow when full.
    add_req(fdsa_pkg::OP_DROP, 0);
    add_req(fdsa_pkg::OP_SWAP, 0);
    add_req(fdsa_pkg::OP_ADD, 0);
    add_req(fdsa_pkg::OP_PUSH, 32'h8000_0000);
    add_req(fdsa_pkg::OP_ABS, 0);
    add_req(fdsa_pkg::OP_NEG, 0);
    add_req(fdsa_pkg::OP_PUSH, 32'hffff_ffff);
    add_req(fdsa_pkg::OP_DIV, 0);
    add_req(fdsa_pkg::OP_PUSH, 32'h8000_0000);
    add_req(fdsa_pkg::OP_PUSH, 32'hffff_ffff);
    add_req(fdsa_pkg::OP_MOD, 0);
    add_req(fdsa_pkg::OP_PUSH, 0);
    add_req(fdsa_pkg::OP_DIV, 0);
    add_req(fdsa_pkg::OP_MOD, 0);
    add_req(fdsa_pkg::OP_QDUP, 0);
    add_req(fdsa_pkg::OP_PUSH, 32'h7fff_ffff);
    add_req(fdsa_pkg::OP_QDUP, 0);
    add_req(OP_RSV_LO, 0);
    add_req(OP_RSV_HI, 32'hffff_ffff);
    add_req(fdsa_pkg::OP_DROP, 0);
    for (int i = 0; i < 32; i++) add_req(fdsa_pkg::OP_PUSH, (i == 0) ? 32'd0 : $urandom);
    add_req(fdsa_pkg::OP_PUSH, 1);
    add_req(fdsa_pkg::OP_DUP, 0);
    add_req(fdsa_pkg::OP_OVER, 0);
    add_req(fdsa_pkg::OP_QDUP, 0);

    // Random: about a third pushes, other opcodes random, with occasional bursts of drops.
    n = 0;
    while (n < 400) begin
      if ($urandom_range(0, 39) == 0) begin
        fill = $urandom_range(0, 33);
        for (int i = 0; i < fill; i++) add_req(fdsa_pkg::OP_DROP, 0);
        n += fill;
      end
      if ($urandom_range(0, 2) == 0) op = fdsa_pkg::OP_PUSH;
      else op = 5'($urandom_range(0, 31));
      add_req(op, rand_word());
      n++;
    end

    wait (pending_reqs.size() == 0 && !req_valid);
    wait (expected_rsps.size() == 0);
    repeat (100) @(posedge clk);
    if (mismatches == 0 && expected_rsps.size() == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("simulation failed");
    $finish;
  end

endmodule
